@@ hdl/detc_pkg.sv @@
// ----------------------------------------------------------------------------
// detc_pkg: shared types and codes for the dual extreme trend classifier
// Trend codes, register indexes and turn flag bit positions.
// ----------------------------------------------------------------------------
package detc_pkg;

   // trend classification of one pair of extremes
   typedef logic [1:0] trend_type;
   localparam trend_type TREND_NEUTRAL = 2'd0;
   localparam trend_type TREND_DOWN    = 2'd1;
   localparam trend_type TREND_UP      = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_WINDOW_LENGTH  = 1'b0;
   localparam csr_index_type CSR_HISTORY_LENGTH = 1'b1;
   localparam int CSR_DATA_BITS = 16;

   // configuration reset values
   localparam logic [8:0]  WINDOW_LENGTH_RESET  = 9'd240;
   localparam logic [15:0] HISTORY_LENGTH_RESET = 16'd240;
   localparam int WINDOW_LENGTH_MIN = 4;

   // turn flag bit positions
   typedef logic [3:0] turn_flags_type;
   localparam int FLAG_HIGH_START = 0;  // may seek older high
   localparam int FLAG_HIGH_REV   = 1;  // high curve turned back up
   localparam int FLAG_LOW_START  = 2;  // may seek older low
   localparam int FLAG_LOW_REV    = 3;  // low curve turned back down

endpackage

@@ hdl/dual_extreme_trend_classifier.sv @@
// ----------------------------------------------------------------------------
// dual_extreme_trend_classifier
// Scans windows of samples (newest first), tracks recent and older highs and
// lows, and at each window end classifies both pairs and gives positions.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req_    | in        | req_valid/req_stall  | sample, series_kind
//   rsp_    | out       | rsp_valid/rsp_stall  | kind_echo, trends, positions,
//           |           |                      | window_error
//   csr_    | in        | csr_write            | csr_index, csr_wdata
//
// One word is accepted per cycle while req_stall is low; the extreme tracking
// updates its state registers in the cycle of acceptance. A finished window
// passes through a snapshot stage, a difference stage and the output stage
// register before it reaches rsp_. Reset (synchronous) clears the window state
// and loads the register defaults. A stalled output holds; the two internal
// stages keep taking words until they are full, then req_stall rises.
//
module dual_extreme_trend_classifier #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  logic                              req_series_kind,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind_echo,
   output detc_pkg::trend_type               rsp_upper_trend,
   output detc_pkg::trend_type               rsp_lower_trend,
   output logic [15:0]                       rsp_older_high_pos,
   output logic [15:0]                       rsp_recent_high_pos,
   output logic [15:0]                       rsp_older_low_pos,
   output logic [15:0]                       rsp_recent_low_pos,
   output logic                              rsp_window_error,
   // configuration port
   input  logic                              csr_write,
   input  detc_pkg::csr_index_type           csr_index,
   input  logic [detc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int AGE_W = $clog2(MAX_WINDOW);
   localparam int CW    = (WIN_W > 9) ? WIN_W : 9;
   localparam int DW    = SAMPLE_BITS + 2;
   localparam int MW    = SAMPLE_BITS + 6;

   // configuration
   logic [8:0]  window_length_ff;
   logic [15:0] history_length_ff;

   // window state
   logic [AGE_W-1:0]              count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_BITS-1:0] ohv_ff, ohv_in, rhv_ff, rhv_in;
   logic signed [SAMPLE_BITS-1:0] olv_ff, olv_in, rlv_ff, rlv_in;
   logic [AGE_W-1:0]              oha_ff, oha_in, rha_ff, rha_in;
   logic [AGE_W-1:0]              ola_ff, ola_in, rla_ff, rla_in;
   detc_pkg::turn_flags_type      flags_ff, flags_in;
   logic                          win_end;

   // effective window
   logic [CW-1:0]    wl_c;
   logic [CW-1:0]    w_c;
   logic [WIN_W-1:0] win;
   logic [WIN_W-1:0] half;

   // handshake
   logic req_acc;
   logic out_rdy, b_rdy, a_rdy;

   // snapshot stage
   logic                          a_v_ff;
   logic                          a_kind_ff;
   logic signed [SAMPLE_BITS-1:0] a_ohv_ff, a_rhv_ff, a_olv_ff, a_rlv_ff;
   logic [AGE_W-1:0]              a_oha_ff, a_rha_ff, a_ola_ff, a_rla_ff;

   // difference stage
   logic                          b_v_ff;
   logic                          b_kind_ff;
   logic signed [DW-1:0]          b_dh_ff, b_refh_ff, b_dl_ff, b_refl_ff;
   logic [15:0]                   b_ohp_ff, b_rhp_ff, b_olp_ff, b_rlp_ff;
   logic                          b_err_ff;
   logic signed [SAMPLE_BITS-1:0] top_c, bot_c;

   // output stage
   logic                rsp_v_ff;
   logic                rsp_kind_ff;
   detc_pkg::trend_type rsp_up_ff, rsp_lo_ff;
   logic [15:0]         rsp_ohp_ff, rsp_rhp_ff, rsp_olp_ff, rsp_rlp_ff;
   logic                rsp_err_ff;

   // classify one pair: neutral when 20 * |d| <= |r|
   function automatic detc_pkg::trend_type classify(input logic signed [DW-1:0] d,
                                                    input logic signed [DW-1:0] r);
      logic [DW-1:0] ad;
      logic [DW-1:0] ar;
      logic [MW-1:0] m20;
      ad  = (d < 0) ? DW'(-d) : DW'(d);
      ar  = (r < 0) ? DW'(-r) : DW'(r);
      m20 = (MW'(ad) << 4) + (MW'(ad) << 2);
      if (m20 <= MW'(ar)) begin
         return detc_pkg::TREND_NEUTRAL;
      end
      return (d > 0) ? detc_pkg::TREND_DOWN : detc_pkg::TREND_UP;
   endfunction

   // clamp window length into 4..MAX_WINDOW
   always_comb begin
      wl_c = CW'(window_length_ff);
      if (wl_c < CW'(detc_pkg::WINDOW_LENGTH_MIN)) begin
         w_c = CW'(detc_pkg::WINDOW_LENGTH_MIN);
      end else if (wl_c > CW'(MAX_WINDOW)) begin
         w_c = CW'(MAX_WINDOW);
      end else begin
         w_c = wl_c;
      end
      win  = WIN_W'(w_c);
      half = win >> 1;
   end

   // ready chain from the output back to the input
   assign out_rdy   = !rsp_v_ff || !rsp_stall;
   assign b_rdy     = !b_v_ff || out_rdy;
   assign a_rdy     = !a_v_ff || b_rdy;
   assign req_stall = !a_rdy;
   assign req_acc   = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= detc_pkg::WINDOW_LENGTH_RESET;
         history_length_ff <= detc_pkg::HISTORY_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            detc_pkg::CSR_WINDOW_LENGTH:  window_length_ff  <= csr_wdata[8:0];
            detc_pkg::CSR_HISTORY_LENGTH: history_length_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // extreme tracking for one word
   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      ohv_in   = ohv_ff;
      rhv_in   = rhv_ff;
      olv_in   = olv_ff;
      rlv_in   = rlv_ff;
      oha_in   = oha_ff;
      rha_in   = rha_ff;
      ola_in   = ola_ff;
      rla_in   = rla_ff;
      flags_in = flags_ff;
      win_end  = 1'b0;
      if (req_acc) begin
         prev_in = req_sample;
         if (count_ff == '0) begin
            // open a new window
            rhv_in   = req_sample;
            rlv_in   = req_sample;
            rha_in   = '0;
            rla_in   = '0;
            ohv_in   = '0;
            olv_in   = '0;
            oha_in   = AGE_W'(win - WIN_W'(1));
            ola_in   = AGE_W'(win - WIN_W'(1));
            flags_in = '0;
            count_in = AGE_W'(1);
         end else begin
            // first half: track recent extremes, restart turn search on a new one
            if (WIN_W'(count_ff) < half) begin
               if (req_sample > rhv_ff) begin
                  rhv_in = req_sample;
                  rha_in = count_ff;
                  flags_in[detc_pkg::FLAG_HIGH_START] = 1'b0;
                  flags_in[detc_pkg::FLAG_HIGH_REV]   = 1'b0;
               end else if (req_sample < rlv_ff) begin
                  rlv_in = req_sample;
                  rla_in = count_ff;
                  flags_in[detc_pkg::FLAG_LOW_START] = 1'b0;
                  flags_in[detc_pkg::FLAG_LOW_REV]   = 1'b0;
               end
            end
            // look for the turn down then up (highs), up then down (lows)
            if (!flags_in[detc_pkg::FLAG_HIGH_START]) begin
               if (req_sample < prev_ff) flags_in[detc_pkg::FLAG_HIGH_START] = 1'b1;
            end else if (!flags_in[detc_pkg::FLAG_HIGH_REV] && req_sample > prev_ff) begin
               flags_in[detc_pkg::FLAG_HIGH_REV] = 1'b1;
               ohv_in = req_sample;
               oha_in = count_ff;
            end
            if (!flags_in[detc_pkg::FLAG_LOW_START]) begin
               if (req_sample > prev_ff) flags_in[detc_pkg::FLAG_LOW_START] = 1'b1;
            end else if (!flags_in[detc_pkg::FLAG_LOW_REV] && req_sample < prev_ff) begin
               flags_in[detc_pkg::FLAG_LOW_REV] = 1'b1;
               olv_in = req_sample;
               ola_in = count_ff;
            end
            // second half: track older extremes after the turn
            if (WIN_W'(count_ff) >= half) begin
               if (flags_in[detc_pkg::FLAG_HIGH_START] && flags_in[detc_pkg::FLAG_HIGH_REV] &&
                   (req_sample > ohv_in || WIN_W'(oha_in) < half)) begin
                  ohv_in = req_sample;
                  oha_in = count_ff;
               end
               if (flags_in[detc_pkg::FLAG_LOW_START] && flags_in[detc_pkg::FLAG_LOW_REV] &&
                   (req_sample < olv_in || WIN_W'(ola_in) < half)) begin
                  olv_in = req_sample;
                  ola_in = count_ff;
               end
            end
            // advance or close the window
            if (WIN_W'(count_ff) + WIN_W'(1) < win) begin
               count_in = count_ff + AGE_W'(1);
            end else begin
               count_in = '0;
               win_end  = 1'b1;
            end
         end
      end
   end

   // window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= '0;
         ohv_ff   <= '0;
         rhv_ff   <= '0;
         olv_ff   <= '0;
         rlv_ff   <= '0;
         oha_ff   <= '0;
         rha_ff   <= '0;
         ola_ff   <= '0;
         rla_ff   <= '0;
         flags_ff <= '0;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         ohv_ff   <= ohv_in;
         rhv_ff   <= rhv_in;
         olv_ff   <= olv_in;
         rlv_ff   <= rlv_in;
         oha_ff   <= oha_in;
         rha_ff   <= rha_in;
         ola_ff   <= ola_in;
         rla_ff   <= rla_in;
         flags_ff <= flags_in;
      end
   end

   // snapshot stage: hold the extremes of a finished window
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_rdy) begin
         a_v_ff <= win_end;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && win_end) begin
         a_kind_ff <= req_series_kind;
         a_ohv_ff  <= ohv_in;
         a_rhv_ff  <= rhv_in;
         a_olv_ff  <= olv_in;
         a_rlv_ff  <= rlv_in;
         a_oha_ff  <= oha_in;
         a_rha_ff  <= rha_in;
         a_ola_ff  <= ola_in;
         a_rla_ff  <= rla_in;
      end
   end

   // difference stage: gaps, references and positions
   assign top_c = (a_ohv_ff > a_rhv_ff) ? a_ohv_ff : a_rhv_ff;
   assign bot_c = (a_olv_ff < a_rlv_ff) ? a_olv_ff : a_rlv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_rdy) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_rdy && a_v_ff) begin
         b_kind_ff <= a_kind_ff;
         b_dh_ff   <= DW'(a_ohv_ff) - DW'(a_rhv_ff);
         b_refh_ff <= DW'(top_c) - DW'(bot_c);
         b_dl_ff   <= DW'(a_olv_ff) - DW'(a_rlv_ff);
         b_refl_ff <= DW'(a_olv_ff);
         b_ohp_ff  <= history_length_ff - 16'(a_oha_ff) - 16'd1;
         b_rhp_ff  <= history_length_ff - 16'(a_rha_ff) - 16'd1;
         b_olp_ff  <= history_length_ff - 16'(a_ola_ff) - 16'd1;
         b_rlp_ff  <= history_length_ff - 16'(a_rla_ff) - 16'd1;
         b_err_ff  <= history_length_ff < 16'(win);
      end
   end

   // output stage: classify and hold the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && b_v_ff) begin
         rsp_kind_ff <= b_kind_ff;
         rsp_up_ff   <= classify(b_dh_ff, b_refh_ff);
         rsp_lo_ff   <= classify(b_dl_ff, b_refl_ff);
         rsp_ohp_ff  <= b_ohp_ff;
         rsp_rhp_ff  <= b_rhp_ff;
         rsp_olp_ff  <= b_olp_ff;
         rsp_rlp_ff  <= b_rlp_ff;
         rsp_err_ff  <= b_err_ff;
      end
   end

   assign rsp_valid           = rsp_v_ff;
   assign rsp_kind_echo       = rsp_kind_ff;
   assign rsp_upper_trend     = rsp_up_ff;
   assign rsp_lower_trend     = rsp_lo_ff;
   assign rsp_older_high_pos  = rsp_ohp_ff;
   assign rsp_recent_high_pos = rsp_rhp_ff;
   assign rsp_older_low_pos   = rsp_olp_ff;
   assign rsp_recent_low_pos  = rsp_rlp_ff;
   assign rsp_window_error    = rsp_err_ff;

   // recent high never falls below recent low
   assert property (@(posedge clock) disable iff (reset) rhv_ff >= rlv_ff)
      else $error("recent high below recent low");

   // a turn back is only seen after the turn away
   assert property (@(posedge clock) disable iff (reset)
      !(flags_ff[detc_pkg::FLAG_HIGH_REV] && !flags_ff[detc_pkg::FLAG_HIGH_START]) &&
      !(flags_ff[detc_pkg::FLAG_LOW_REV] && !flags_ff[detc_pkg::FLAG_LOW_START]))
      else $error("turn flags out of order");

   // a word that opens a window moves the count to one
   assert property (@(posedge clock) disable iff (reset)
      req_acc && count_ff == '0 |=> count_ff == AGE_W'(1))
      else $error("window did not open");

   // a closing word lands in the snapshot stage
   assert property (@(posedge clock) disable iff (reset)
      win_end |=> a_v_ff && count_ff == '0)
      else $error("finished window lost");

endmodule
